// ===== sv/pjq_pkg.sv =====
// ----------------------------------------------------------------------------
// pjq_pkg
// Shared types, status codes and constants for the priority job queue.
// ----------------------------------------------------------------------------
package pjq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 128;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned PRIO_W  = 9;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CAP_W   = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

  localparam logic [STAT_W-1:0] ST_INSERTED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_BUSY       = 3'd1;
  localparam logic [STAT_W-1:0] ST_DISPATCHED = 3'd2;
  localparam logic [STAT_W-1:0] ST_CANCELLED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd4;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_SERVICE = 1'b1;

  localparam logic signed [PRIO_W-1:0] CANCEL_MARK = -9'sd1;

  typedef struct packed {
    logic        [ID_W-1:0]   id;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

// ===== sv/pjq_if.sv =====
// ----------------------------------------------------------------------------
// pjq_in_if / pjq_out_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface pjq_in_if;
  import pjq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic        [ID_W-1:0]   job_id;
  logic signed [PRIO_W-1:0] priority_req;

  modport source (output valid, func, job_id, priority_req, input ready);
  modport sink   (input valid, func, job_id, priority_req, output ready);
endinterface

interface pjq_out_if;
  import pjq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [STAT_W-1:0] status;
  logic        [ID_W-1:0]   out_job_id;
  logic signed [PRIO_W-1:0] out_priority;
  logic        [COUNT_W-1:0] count;

  modport source (output valid, status, out_job_id, out_priority, count, input ready);
  modport sink   (input valid, status, out_job_id, out_priority, count, output ready);
endinterface

// ===== sv/pjq_cell.sv =====
// ----------------------------------------------------------------------------
// pjq_cell
// One slot of the sorted queue: shifts right on insert, left on removal.
// ----------------------------------------------------------------------------
module pjq_cell (
  input  logic                clk,
  input  pjq_pkg::cell_ctrl_t ctrl,
  input  logic                valid,
  input  pjq_pkg::entry_t     new_entry,
  input  pjq_pkg::entry_t     left_entry,
  input  logic                left_open,
  input  pjq_pkg::entry_t     right_entry,
  output pjq_pkg::entry_t     entry,
  output logic                open
);
  import pjq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // open: the new entry belongs here or further toward the head
  assign open  = !valid || (entry_r.prio < new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.insert && open) begin
      entry_nxt = left_open ? left_entry : new_entry;
    end else if (ctrl.remove) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== sv/priority_job_queue.sv =====
// ----------------------------------------------------------------------------
// priority_job_queue
// The result transaction is registered and appears in the cycle after the request.
// Throughput: one transaction per cycle while the result side takes results; each
// cell compares and shifts in parallel. The output register frees as the result is
// taken, so a stall on the result side stalls the request side for as long.
// Reset (rst_n, synchronous): queue empty, capacity 128, no result pending.
// ----------------------------------------------------------------------------
module priority_job_queue #(
  parameter int unsigned QUEUE_DEPTH = pjq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  pjq_in_if.sink                   in_if,
  pjq_out_if.source                out_if,
  input  logic                     cfg_we,
  input  logic [pjq_pkg::CAP_W-1:0] cfg_wdata
);
  import pjq_pkg::*;

  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LIM_W = 10;

  logic [CAP_W-1:0]  cap_r;
  logic [OCC_W-1:0]  occ_r;
  logic [OCC_W-1:0]  occ_nxt;
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic [STAT_W-1:0] status_nxt;
  logic [ID_W-1:0]   oid_r;
  logic [ID_W-1:0]   oid_nxt;
  logic signed [PRIO_W-1:0] oprio_r;
  logic signed [PRIO_W-1:0] oprio_nxt;

  logic              accept;
  logic              busy;
  logic [LIM_W-1:0]  lim;
  logic [8:0]        occ_wide;
  cell_ctrl_t        ctrl;
  entry_t            new_entry;
  entry_t            cell_q [QUEUE_DEPTH];
  logic              open   [QUEUE_DEPTH];

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  assign lim  = (LIM_W'(cap_r) < LIM_W'(QUEUE_DEPTH)) ? LIM_W'(cap_r) : LIM_W'(QUEUE_DEPTH);
  assign busy = LIM_W'(occ_r) >= lim;

  assign new_entry.id   = in_if.job_id;
  assign new_entry.prio = in_if.priority_req;

  always_comb begin
    ctrl       = '0;
    occ_nxt    = occ_r;
    status_nxt = status_r;
    oid_nxt    = oid_r;
    oprio_nxt  = oprio_r;
    if (accept) begin
      oid_nxt   = '0;
      oprio_nxt = '0;
      if (in_if.func == FUNC_INSERT) begin
        if (busy) begin
          status_nxt = ST_BUSY;
        end else begin
          ctrl.insert = 1'b1;
          occ_nxt     = occ_r + 1'b1;
          status_nxt  = ST_INSERTED;
        end
      end else begin
        if (occ_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.remove = 1'b1;
          occ_nxt     = occ_r - 1'b1;
          oid_nxt     = cell_q[0].id;
          oprio_nxt   = cell_q[0].prio;
          status_nxt  = (cell_q[0].prio == CANCEL_MARK) ? ST_CANCELLED : ST_DISPATCHED;
        end
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_t left_e;
      entry_t right_e;
      logic   left_o;
      if (i == 0) begin : g_head
        assign left_e = '0;
        assign left_o = 1'b0;
      end else begin : g_mid
        assign left_e = cell_q[i-1];
        assign left_o = open[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign right_e = cell_q[i];
      end else begin : g_body
        assign right_e = cell_q[i+1];
      end
      pjq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .valid       (occ_r > OCC_W'(i)),
        .new_entry   (new_entry),
        .left_entry  (left_e),
        .left_open   (left_o),
        .right_entry (right_e),
        .entry       (cell_q[i]),
        .open        (open[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      occ_r <= occ_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    oid_r    <= oid_nxt;
    oprio_r  <= oprio_nxt;
  end

  assign occ_wide            = 9'(occ_r);
  assign out_if.valid        = out_valid_r;
  assign out_if.status       = status_r;
  assign out_if.out_job_id   = oid_r;
  assign out_if.out_priority = oprio_r;
  assign out_if.count        = occ_wide[COUNT_W-1:0];

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LIM_W'(occ_r) <= LIM_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_if.func == FUNC_INSERT && !busy |=> occ_r == $past(occ_r) + 1'b1)
    else $error("insert did not grow the queue");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_EMPTY |-> occ_wide == '0 && oid_r == '0)
    else $error("empty result with queued jobs or nonzero id");

  a_cancel_prio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_CANCELLED |-> oprio_r == CANCEL_MARK)
    else $error("cancelled result without cancel priority");
`endif

endmodule

// ===== verif/job_queue_checker.sv =====
// ----------------------------------------------------------------------------
// job_queue_checker
// Watches the request and result channels of the priority job queue. Every
// accepted request goes through a sorted-queue predictor at the same edge,
// and its expected result is held until the matching result transaction is
// checked field by field. Mismatches and the number of outstanding results
// go back to the testbench top.
// ----------------------------------------------------------------------------
module job_queue_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  pjq_in_if                         in_ch,
  pjq_out_if                        out_ch,
  input  logic                      cfg_we,
  input  logic [pjq_pkg::CAP_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pjq_pkg::*;

  typedef struct packed {
    logic        [STAT_W-1:0]  status;
    logic        [ID_W-1:0]    id;
    logic signed [PRIO_W-1:0]  prio;
    logic        [COUNT_W-1:0] count;
  } job_result_t;

  entry_t            job_store [QUEUE_DEPTH_DEF];
  int unsigned       jobs_held;
  logic [CAP_W-1:0]  cap_setting;
  job_result_t       awaited_results [$];

  function automatic job_result_t apply_job(logic func, logic [ID_W-1:0] id,
                                            logic signed [PRIO_W-1:0] prio);
    job_result_t res;
    int unsigned limit;
    int unsigned pos;
    res = '0;
    if (func == FUNC_INSERT) begin
      limit = (cap_setting > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : cap_setting;
      if (jobs_held >= limit) begin
        res.status = ST_BUSY;
      end else begin
        pos = jobs_held;
        for (int i = 0; i < jobs_held; i++) begin
          if ($signed(job_store[i].prio) < $signed(prio)) begin
            pos = i;
            break;
          end
        end
        for (int i = jobs_held; i > pos; i--) begin
          job_store[i] = job_store[i-1];
        end
        job_store[pos].id   = id;
        job_store[pos].prio = prio;
        jobs_held++;
        res.status = ST_INSERTED;
      end
    end else begin
      if (jobs_held == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.id     = job_store[0].id;
        res.prio   = job_store[0].prio;
        res.status = (job_store[0].prio == CANCEL_MARK) ? ST_CANCELLED : ST_DISPATCHED;
        for (int i = 1; i < jobs_held; i++) begin
          job_store[i-1] = job_store[i];
        end
        jobs_held--;
      end
    end
    res.count = COUNT_W'(jobs_held);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    job_result_t want;
    if (!rst_n) begin
      jobs_held   = 0;
      cap_setting = CAP_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        cap_setting = cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result transaction", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", int'(out_ch.status), int'(want.status));
          if (out_ch.out_job_id !== want.id)
            report_mismatch("out_job_id", int'(out_ch.out_job_id), int'(want.id));
          if (out_ch.out_priority !== want.prio)
            report_mismatch("out_priority", int'($signed(out_ch.out_priority)),
                            int'($signed(want.prio)));
          if (out_ch.count !== want.count)
            report_mismatch("count", int'(out_ch.count), int'(want.count));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        awaited_results.push_back(apply_job(in_ch.func, in_ch.job_id, in_ch.priority_req));
      end
    end
    outstanding <= awaited_results.size();
  end

endmodule

// ===== verif/tb_priority_job_queue.sv =====
// ----------------------------------------------------------------------------
// tb_priority_job_queue
// Drives job inserts and head services into the priority job queue with
// random gaps and result-side stalls, across several capacity settings.
// A directed part covers empty service, cancelled heads, negative and
// extreme priorities, ties and a full queue; random phases then push the
// queue up to its depth and back. Checking lives in job_queue_checker.
// ----------------------------------------------------------------------------
module tb_priority_job_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import pjq_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  int               mismatches;
  int               pending;
  int               cycle_count;
  int               jobs_sent;
  int               cap_writes;
  bit               no_gaps;

  pjq_in_if  req_ch ();
  pjq_out_if res_ch ();

  priority_job_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_ch),
    .out_if    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  job_queue_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_ch),
    .out_ch      (res_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (mismatches),
    .outstanding (pending)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("[priority_job_queue] ERROR");
      $finish;
    end
  end

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 27);
    end
  end

  task automatic send_job(logic func, logic [ID_W-1:0] id, logic signed [PRIO_W-1:0] prio);
    while (!no_gaps && $urandom_range(0, 99) < 27) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.func         <= func;
    req_ch.job_id       <= id;
    req_ch.priority_req <= prio;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    jobs_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_writes++;
  endtask

  task automatic random_job(int insert_pct);
    logic signed [PRIO_W-1:0] prio;
    case ($urandom_range(0, 3))
      0:       prio = CANCEL_MARK;
      1:       prio = PRIO_W'($urandom_range(0, 3));
      default: prio = PRIO_W'($urandom_range(0, 511));
    endcase
    send_job(($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_SERVICE,
             ID_W'($urandom_range(0, 255)), prio);
  endtask

  initial begin
    int phase_cap [7]   = '{3, 0, 255, 128, 37, 1, 128};
    int phase_jobs [7]  = '{40, 12, 180, 50, 60, 30, 60};
    int phase_ins [7]   = '{60, 50, 88, 15, 65, 50, 10};
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.func         <= FUNC_INSERT;
    req_ch.job_id       <= '0;
    req_ch.priority_req <= '0;
    no_gaps             = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty, extremes, ties, cancelled head, negative priorities
    send_job(FUNC_SERVICE, 8'd255, 9'sd255);
    send_job(FUNC_INSERT, 8'd0, 9'sd0);
    send_job(FUNC_INSERT, 8'd255, 9'sd255);
    send_job(FUNC_INSERT, 8'd1, -9'sd256);
    send_job(FUNC_INSERT, 8'd2, CANCEL_MARK);
    send_job(FUNC_INSERT, 8'd3, 9'sd0);
    send_job(FUNC_INSERT, 8'd4, -9'sd2);
    repeat (7) send_job(FUNC_SERVICE, 8'd0, 9'sd0);
    write_capacity(8'd0);
    send_job(FUNC_INSERT, 8'd170, 9'sd85);
    send_job(FUNC_SERVICE, 8'd85, -9'sd86);
    write_capacity(8'd1);
    send_job(FUNC_INSERT, 8'd7, CANCEL_MARK);
    send_job(FUNC_INSERT, 8'd8, 9'sd254);
    send_job(FUNC_SERVICE, 8'd0, 9'sd0);
    send_job(FUNC_SERVICE, 8'd0, 9'sd0);

    for (int p = 0; p < 7; p++) begin
      write_capacity(CAP_W'(phase_cap[p]));
      no_gaps = (p == 3);
      for (int n = 0; n < phase_jobs[p]; n++) begin
        if (p == 2 && n == phase_jobs[p] / 2) wait_drained();
        random_job(phase_ins[p]);
      end
    end
    no_gaps = 1'b0;

    wait_drained();
    repeat (4) @(posedge clk);
    $display("run covered %0d jobs over %0d capacity writes (0, 1, 255 included),",
             jobs_sent, cap_writes);
    $display("with queue fill to full depth, ties, cancelled heads and empty services");
    if (mismatches == 0 && pending == 0) begin
      $display("[priority_job_queue] OK");
    end else begin
      $display("[priority_job_queue] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pjq_pkg.sv
sv/pjq_if.sv
sv/pjq_cell.sv
sv/priority_job_queue.sv
verif/job_queue_checker.sv
verif/tb_priority_job_queue.sv
